// ===== rtl/osp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osp_pkg: shared types and constants
// Fixed-point constants, command codes and the arctangent table of the
// subsatellite point propagator.
// ----------------------------------------------------------------------------
package osp_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int ITER_W       = 5;   // holds CORDIC_STEPS-1
  localparam int VW           = 34;  // CORDIC x/y/z width
  localparam int MUL_W        = 2 * VW;
  localparam int DIV_W        = 77;  // dividend / quotient width
  localparam int DSOR_W       = 31;  // divisor width
  localparam int REM_W        = DSOR_W + 1;
  localparam int SQ_W         = 64;
  localparam int CNT_W        = 7;   // holds DIV_W-1

  localparam logic [61:0] ROOT_MU_TURN = 62'd3493726033800000000;
  localparam logic [24:0] EARTH_RADIUS = 25'd6371000;
  localparam logic [31:0] EARTH_RATE   = 32'd3266731837;
  localparam logic [30:0] INV_GAIN     = 31'd652032874;

  // register indexes
  localparam logic [1:0] REG_HEIGHT = 2'd0;
  localparam logic [1:0] REG_INCL   = 2'd1;
  localparam logic [1:0] REG_NODE   = 2'd2;
  localparam logic [1:0] REG_START  = 2'd3;

  // datapath command codes
  typedef logic [3:0] op_t;
  localparam op_t OP_NOP      = 4'd0;
  localparam op_t OP_LOAD     = 4'd1;
  localparam op_t OP_DIVSTEP  = 4'd2;
  localparam op_t OP_DIV2     = 4'd3;
  localparam op_t OP_MUL_N    = 4'd4;
  localparam op_t OP_MUL_E    = 4'd5;
  localparam op_t OP_EARTH    = 4'd6;
  localparam op_t OP_ROT_M    = 4'd7;
  localparam op_t OP_STEP     = 4'd8;
  localparam op_t OP_MUL_S    = 4'd9;
  localparam op_t OP_ROT_I    = 4'd10;
  localparam op_t OP_VEC1     = 4'd11;
  localparam op_t OP_MUL_M    = 4'd12;
  localparam op_t OP_VEC2     = 4'd13;
  localparam op_t OP_EMIT     = 4'd14;

  typedef struct packed {
    op_t               op;
    logic [ITER_W-1:0] iter;
  } osp_cmd_t;

  typedef struct packed {
    logic out_free;
  } osp_status_t;

  typedef struct packed {
    logic        wr;
    logic [1:0]  index;
    logic [31:0] data;
  } osp_cfg_t;

  // atan(2^-i) in turns, 2^32 per turn
  function automatic logic [31:0] atan_turn(input logic [ITER_W-1:0] i);
    logic [31:0] r;
    case (i)
      5'd0:    r = 32'd536870912;
      5'd1:    r = 32'd316933406;
      5'd2:    r = 32'd167458907;
      5'd3:    r = 32'd85004756;
      5'd4:    r = 32'd42667331;
      5'd5:    r = 32'd21354465;
      5'd6:    r = 32'd10679838;
      5'd7:    r = 32'd5340245;
      5'd8:    r = 32'd2670163;
      5'd9:    r = 32'd1335087;
      5'd10:   r = 32'd667544;
      5'd11:   r = 32'd333772;
      5'd12:   r = 32'd166886;
      5'd13:   r = 32'd83443;
      5'd14:   r = 32'd41722;
      5'd15:   r = 32'd20861;
      5'd16:   r = 32'd10430;
      5'd17:   r = 32'd5215;
      5'd18:   r = 32'd2608;
      5'd19:   r = 32'd1304;
      5'd20:   r = 32'd652;
      5'd21:   r = 32'd326;
      5'd22:   r = 32'd163;
      5'd23:   r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/osp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osp_ctrl: sequencer
// Steps the datapath through root, divisions, angle updates and four
// CORDIC passes for each accepted word.
// ----------------------------------------------------------------------------
module osp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  osp_pkg::osp_status_t status,
  output osp_pkg::osp_cmd_t    cmd
);
  import osp_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIV1  = 4'd1;
  localparam logic [3:0] S_DIV2L = 4'd2;
  localparam logic [3:0] S_DIV2  = 4'd3;
  localparam logic [3:0] S_MULN  = 4'd4;
  localparam logic [3:0] S_MULE  = 4'd5;
  localparam logic [3:0] S_EARTH = 4'd6;
  localparam logic [3:0] S_ROTM  = 4'd7;
  localparam logic [3:0] S_CORD  = 4'd8;
  localparam logic [3:0] S_MULS  = 4'd9;
  localparam logic [3:0] S_ROTI  = 4'd10;
  localparam logic [3:0] S_VEC1  = 4'd11;
  localparam logic [3:0] S_MULM  = 4'd12;
  localparam logic [3:0] S_VEC2  = 4'd13;
  localparam logic [3:0] S_EMIT  = 4'd14;

  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DIV_W - 1);
  localparam logic [CNT_W-1:0] CORD_LAST = CNT_W'(CORDIC_STEPS - 1);

  logic [3:0]       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [1:0]       leg, leg_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    leg_next   = leg;
    cmd.op     = OP_NOP;
    cmd.iter   = cnt[ITER_W-1:0];
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          cnt_next   = '0;
          leg_next   = '0;
          state_next = S_DIV1;
        end
      end
      S_DIV1, S_DIV2: begin
        cmd.op   = OP_DIVSTEP;
        cnt_next = cnt + 1'b1;
        if (cnt == DIV_LAST) begin
          cnt_next   = '0;
          state_next = (state == S_DIV1) ? S_DIV2L : S_MULN;
        end
      end
      S_DIV2L: begin
        cmd.op     = OP_DIV2;
        state_next = S_DIV2;
      end
      S_MULN: begin
        cmd.op     = OP_MUL_N;
        state_next = S_MULE;
      end
      S_MULE: begin
        cmd.op     = OP_MUL_E;
        state_next = S_EARTH;
      end
      S_EARTH: begin
        cmd.op     = OP_EARTH;
        state_next = S_ROTM;
      end
      S_ROTM: begin
        cmd.op     = OP_ROT_M;
        state_next = S_CORD;
      end
      S_CORD: begin
        cmd.op   = OP_STEP;
        cnt_next = cnt + 1'b1;
        if (cnt == CORD_LAST) begin
          cnt_next = '0;
          leg_next = leg + 1'b1;
          case (leg)
            2'd0:    state_next = S_MULS;
            2'd1:    state_next = S_VEC1;
            2'd2:    state_next = S_MULM;
            default: state_next = S_EMIT;
          endcase
        end
      end
      S_MULS: begin
        cmd.op     = OP_MUL_S;
        state_next = S_ROTI;
      end
      S_ROTI: begin
        cmd.op     = OP_ROT_I;
        state_next = S_CORD;
      end
      S_VEC1: begin
        cmd.op     = OP_VEC1;
        state_next = S_CORD;
      end
      S_MULM: begin
        cmd.op     = OP_MUL_M;
        state_next = S_VEC2;
      end
      S_VEC2: begin
        cmd.op     = OP_VEC2;
        state_next = S_CORD;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.op     = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      leg   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      leg   <= leg_next;
    end
  end

endmodule

// ===== rtl/osp_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osp_dp: datapath
// Config and orbit state, radix-2 divider, bit-pair square root, one
// shared multiplier, one shared CORDIC unit and the output register.
// ----------------------------------------------------------------------------
module osp_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  osp_pkg::osp_cfg_t    cfg,
  input  osp_pkg::osp_cmd_t    cmd,
  output osp_pkg::osp_status_t status,
  input  logic [31:0]          dt_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [31:0]          lat_out,
  output logic [31:0]          lon_out
);
  import osp_pkg::*;

  localparam logic signed [VW-1:0] QUARTER = VW'(64'd1 << 30);
  localparam logic signed [VW-1:0] HALF    = VW'(64'd1 << 31);

  // config and orbit state
  logic [23:0] height;
  logic [30:0] incl;
  logic [31:0] node;
  logic [31:0] mean, earth;

  logic [31:0]             dt;
  logic [DIV_W-1:0]        div_q;
  logic [REM_W-1:0]        div_r;
  logic [DSOR_W-1:0]       div_d;
  logic [SQ_W-1:0]         sq_v, sq_res, sq_bit;
  logic signed [MUL_W-1:0] prod;
  logic signed [VW-1:0]    cx, cy, cz;
  logic                    vec_mode;
  logic signed [VW-1:0]    c_r, q_r, phi_r;
  logic                    rxy_zero;

  // divider step
  logic [REM_W-1:0] rem_sh;
  logic             div_ge;
  assign rem_sh = {div_r[REM_W-2:0], div_q[DIV_W-1]};
  assign div_ge = rem_sh >= {1'b0, div_d};

  // square root step
  logic [SQ_W-1:0] sq_try;
  logic            sq_ge;
  assign sq_try = sq_res + sq_bit;
  assign sq_ge  = sq_v >= sq_try;

  // shared multiplier
  logic signed [VW-1:0] mul_a, mul_b;
  always_comb begin
    case (cmd.op)
      OP_MUL_N: begin
        mul_a = $signed({2'b00, dt});
        mul_b = $signed({2'b00, div_q[31:0]});
      end
      OP_MUL_E: begin
        mul_a = $signed({2'b00, dt});
        mul_b = $signed({2'b00, EARTH_RATE});
      end
      OP_MUL_S: begin
        mul_a = cy;
        mul_b = $signed(VW'(INV_GAIN));
      end
      default: begin
        mul_a = cx;
        mul_b = $signed(VW'(INV_GAIN));
      end
    endcase
  end

  logic [63:0] anom_sum;
  logic [64:0] earth_sum;
  assign anom_sum  = prod[63:0] + 64'd8388608;
  assign earth_sum = {1'b0, prod[63:0]} + 65'd2147483648;

  // rotation pass setup: fold into the half turn around zero
  logic signed [VW-1:0] rx_in, rz_in, rx0, rz0;
  always_comb begin
    if (cmd.op == OP_ROT_M) begin
      rx_in = $signed(VW'(INV_GAIN));
      rz_in = VW'($signed(mean));
    end else begin
      rx_in = prod[63:30];
      rz_in = $signed({3'b000, incl});
    end
    rx0 = rx_in;
    rz0 = rz_in;
    if (rz_in > QUARTER) begin
      rx0 = -rx_in;
      rz0 = rz_in - HALF;
    end else if (rz_in < -QUARTER) begin
      rx0 = -rx_in;
      rz0 = rz_in + HALF;
    end
  end

  // vectoring pass setup: move to the right half plane
  logic signed [VW-1:0] vx_in, vy_in, vx0, vy0, vz0;
  always_comb begin
    if (cmd.op == OP_VEC1) begin
      vx_in = c_r;
      vy_in = cx;
    end else begin
      vx_in = prod[63:30];
      vy_in = q_r;
    end
    if (vx_in < 0) begin
      vx0 = -vx_in;
      vy0 = -vy_in;
      vz0 = HALF;
    end else begin
      vx0 = vx_in;
      vy0 = vy_in;
      vz0 = '0;
    end
  end

  // CORDIC micro-rotation
  logic signed [VW-1:0] dx, dy, at;
  logic                 cw;
  assign dx = cy >>> cmd.iter;
  assign dy = cx >>> cmd.iter;
  assign at = $signed({2'b00, atan_turn(cmd.iter)});
  assign cw = vec_mode ? (cy < 0) : (cz >= 0);

  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      height    <= 24'd400000;
      incl      <= 31'd615611979;
      node      <= '0;
      mean      <= '0;
      earth     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg.wr) begin
        case (cfg.index)
          REG_HEIGHT: height <= cfg.data[23:0];
          REG_INCL:   incl   <= cfg.data[30:0];
          REG_NODE:   node   <= cfg.data;
          REG_START: begin
            mean  <= cfg.data;
            earth <= '0;
          end
          default: ;
        endcase
      end
      if (cmd.op == OP_MUL_E) mean  <= mean + anom_sum[55:24];
      if (cmd.op == OP_EARTH) earth <= earth + earth_sum[63:32];
      if (cmd.op == OP_EMIT)  out_valid <= 1'b1;
      else if (out_ready)     out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        dt     <= dt_in;
        div_q  <= DIV_W'(ROOT_MU_TURN);
        div_r  <= '0;
        div_d  <= DSOR_W'(EARTH_RADIUS + 25'(height));
        sq_v   <= SQ_W'({EARTH_RADIUS + 25'(height), 36'd0});
        sq_res <= '0;
        sq_bit <= SQ_W'(1) << 62;
      end
      OP_DIVSTEP: begin
        div_r <= div_ge ? (rem_sh - {1'b0, div_d}) : rem_sh;
        div_q <= {div_q[DIV_W-2:0], div_ge};
        if (sq_bit != '0) begin
          if (sq_ge) begin
            sq_v   <= sq_v - sq_try;
            sq_res <= (sq_res >> 1) + sq_bit;
          end else begin
            sq_res <= sq_res >> 1;
          end
          sq_bit <= sq_bit >> 2;
        end
      end
      OP_DIV2: begin
        div_q <= {div_q[58:0], 18'd0};
        div_r <= '0;
        div_d <= sq_res[DSOR_W-1:0];
      end
      OP_MUL_N, OP_MUL_E: prod <= mul_a * mul_b;
      OP_ROT_M, OP_ROT_I: begin
        cx       <= rx0;
        cy       <= '0;
        cz       <= rz0;
        vec_mode <= 1'b0;
      end
      OP_STEP: begin
        if (cw) begin
          cx <= cx - dx;
          cy <= cy + dy;
          cz <= cz - at;
        end else begin
          cx <= cx + dx;
          cy <= cy - dy;
          cz <= cz + at;
        end
      end
      OP_MUL_S: begin
        c_r  <= cx;
        prod <= mul_a * mul_b;
      end
      OP_VEC1: begin
        q_r      <= cy;
        cx       <= vx0;
        cy       <= vy0;
        cz       <= vz0;
        vec_mode <= 1'b1;
      end
      OP_MUL_M: begin
        phi_r <= cz;
        prod  <= mul_a * mul_b;
      end
      OP_VEC2: begin
        rxy_zero <= (prod[63:30] == '0);
        cx       <= vx0;
        cy       <= vy0;
        cz       <= vz0;
        vec_mode <= 1'b1;
      end
      OP_EMIT: begin
        lat_out <= cz[31:0];
        lon_out <= rxy_zero ? 32'd0 : (phi_r[31:0] + node - earth);
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/orbit_subpoint_propagator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orbit_subpoint_propagator_core: circular orbit subsatellite point
// Advances mean anomaly and Earth angle by each time step and returns the
// latitude and longitude of the point below the satellite.
// ----------------------------------------------------------------------------
// Each input word is a time step (unsigned Q16.16 s). The core takes one
// word at a time and returns one result word per accepted word; it takes
// the next word only after the result enters the output register, which
// waits while an earlier result is untaken. Each step uses the bit-serial
// divider (two 77-step divisions for the mean motion, square root beside
// the first) and one shared CORDIC unit that makes four 24-step passes:
// two rotations (anomaly, inclination) and two vectorings (longitude,
// latitude). Angles are binary, 2^32 per turn. Longitude is zero at a pole.
// Writing the start anomaly register loads the running anomaly and clears
// the Earth angle; write config only while the core is idle.
// ----------------------------------------------------------------------------
module orbit_subpoint_propagator_core (
  input  logic        clk,
  input  logic        rst,
  // config write port
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // time step stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] dt_seconds
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata    // [31:0] latitude, [63:32] longitude
);
  import osp_pkg::*;

  osp_cmd_t    cmd;
  osp_status_t status;
  osp_cfg_t    cfg;

  assign cfg.wr    = cfg_wr_en;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  // sequencer: owns all step counting
  osp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: state, arithmetic units, output register
  osp_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .status    (status),
    .dt_in     (s_axis_tdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .lat_out   (m_axis_tdata[31:0]),
    .lon_out   (m_axis_tdata[63:32])
  );

  // one word in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while busy");

  // a result appears only from an emit command
  a_emit_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(cmd.op == OP_EMIT))
    else $error("result without emit");

  // emit never overwrites a result that was not taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_EMIT) |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result overwritten");

endmodule

// ===== sim/tb_orbit_subpoint_propagator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_orbit_subpoint_propagator_core: self-checking bench for the propagator
// Drives time steps through the slave stream with random gaps, stalls the
// result stream at random, and checks every latitude / longitude word
// against a bit-exact fixed-point predictor of the orbit and CORDIC math.
// ----------------------------------------------------------------------------
module tb_orbit_subpoint_propagator_core;
  import osp_pkg::REG_HEIGHT;
  import osp_pkg::REG_INCL;
  import osp_pkg::REG_NODE;
  import osp_pkg::REG_START;

  localparam longint unsigned RADIUS_M   = 64'd6371000;
  localparam longint unsigned MU_ROOT    = 64'd3493726033800000000;
  localparam longint unsigned SPIN_RATE  = 64'd3266731837;
  localparam longint          GAIN_COMP  = 64'sd652032874;
  localparam longint unsigned TWO_PI_INV = 64'h28BE60DB9391054A;
  localparam int              STEPS      = 24;

  typedef struct {
    logic signed [31:0] lat;
    logic signed [31:0] lon;
  } subpoint_t;

  // predictor of the subsatellite point plus the queue of pending points
  class subpoint_board;
    bit [23:0] height;
    bit [30:0] incl;
    bit [31:0] node;
    bit [31:0] anomaly;
    bit [31:0] spin;
    longint    atan_tab[STEPS];
    subpoint_t pending[$];
    int        errors;

    function new();
      longint unsigned s, t;
      logic [127:0] p;
      errors = 0;
      height = 24'd400000;
      incl = 31'd615611979;
      node = 0;
      anomaly = 0;
      spin = 0;
      for (int i = 0; i < STEPS; i++) begin
        if (i == 0) begin
          t = 64'd1 << 45;
        end else begin
          s = 0;
          for (int n = 1; i * n <= 62; n += 2) begin
            if (((n >> 1) & 1) == 0) s += (64'd1 << (62 - i * n)) / n;
            else s -= (64'd1 << (62 - i * n)) / n;
          end
          p = {64'd0, s} * {64'd0, TWO_PI_INV};
          t = (p[127:64] + (64'd1 << 13)) >> 14;
        end
        atan_tab[i] = longint'((t + (64'd1 << 15)) >> 16);
      end
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] v);
      case (idx)
        REG_HEIGHT: height = v[23:0];
        REG_INCL:   incl = v[30:0];
        REG_NODE:   node = v;
        REG_START: begin
          anomaly = v;
          spin = 0;
        end
      endcase
    endfunction

    function longint unsigned root64(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    task turn(inout longint x, inout longint y, input longint z);
      longint dx, dy;
      if (z > (64'sd1 <<< 30)) begin
        x = -x; y = -y; z -= 64'sd1 <<< 31;
      end else if (z < -(64'sd1 <<< 30)) begin
        x = -x; y = -y; z += 64'sd1 <<< 31;
      end
      for (int i = 0; i < STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= atan_tab[i];
        end else begin
          x += dx; y -= dy; z += atan_tab[i];
        end
      end
    endtask

    task heading(inout longint x, input longint y, output longint z);
      longint dx, dy;
      z = 0;
      if (x < 0) begin
        x = -x; y = -y; z = 64'sd1 <<< 31;
      end
      for (int i = 0; i < STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y < 0) begin
          x -= dx; y += dy; z -= atan_tab[i];
        end else begin
          x += dx; y -= dy; z += atan_tab[i];
        end
      end
    endtask

    // accepted time step: advance the orbit and queue the expected point
    task note_step(logic [31:0] dt);
      longint unsigned a, n40, d;
      longint x, y, cm, sm, ci, si, rxy, phi, lat;
      subpoint_t sp;
      d = {32'd0, dt};
      a = RADIUS_M + height;
      n40 = ((MU_ROOT / a) << 18) / root64(a << 36);
      anomaly = anomaly + 32'((d * n40 + (64'd1 << 23)) >> 24);
      spin = spin + 32'((d * SPIN_RATE + (64'd1 << 31)) >> 32);
      x = GAIN_COMP; y = 0;
      turn(x, y, longint'(signed'(anomaly)));
      cm = x; sm = y;
      x = (sm * GAIN_COMP) >>> 30; y = 0;
      turn(x, y, longint'(signed'({1'b0, incl})));
      ci = x; si = y;
      x = cm;
      heading(x, ci, phi);
      rxy = (x * GAIN_COMP) >>> 30;
      x = rxy;
      heading(x, si, lat);
      sp.lat = lat[31:0];
      sp.lon = (rxy == 0) ? 32'sd0 : phi[31:0] + node - spin;  // pole: no longitude
      pending.push_back(sp);
    endtask

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t: %s mismatch: got %h want %h", $time, what, got, want);
      errors++;
    endtask

    task check_point(logic [63:0] word);
      subpoint_t sp;
      if (pending.size() == 0) begin
        report("unexpected word", word[31:0], 32'd0);
        return;
      end
      sp = pending.pop_front();
      if (word[31:0] !== sp.lat) report("latitude", word[31:0], sp.lat);
      if (word[63:32] !== sp.lon) report("longitude", word[63:32], sp.lon);
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // [31:0] dt_seconds
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;   // [31:0] latitude, [63:32] longitude

  subpoint_board board;
  bit            calm;         // no idling on either side while set
  int            stall_left;

  orbit_subpoint_propagator_core u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #40ms;
    $display("orbit_subpoint_propagator_core test failed");
    $finish;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    if (calm) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 3);
    return $urandom_range(10, 120);
  endfunction

  // result side: random stalls, checked at every accepted word
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) board.check_point(m_axis_tdata);
    if (rst || calm) begin
      m_axis_tready <= 1'b1;
      stall_left = 0;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      stall_left = pick_gap();
      m_axis_tready <= (stall_left == 0);
    end
  end

  task send_step(logic [31:0] dt);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= dt;
    do @(posedge clk); while (!s_axis_tready);
    board.note_step(dt);
  endtask

  // hold the sender until every pending word has come back
  task drain();
    s_axis_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // one write, then wr_en low again so back-to-back writes never collide
  task write_reg(logic [1:0] idx, logic [31:0] v);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.write_reg(idx, v);
    @(posedge clk);
  endtask

  task set_orbit(logic [31:0] h, logic [31:0] inc, logic [31:0] raan, logic [31:0] m0);
    drain();
    write_reg(REG_HEIGHT, h);
    write_reg(REG_INCL, inc);
    write_reg(REG_NODE, raan);
    write_reg(REG_START, m0);
  endtask

  function automatic logic [31:0] rand_dt();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1, 2:    return $urandom_range(0, 32'h0064_0000);   // up to 100 s
      3:       return $urandom_range(0, 32'h0001_0000);   // up to 1 s
      default: return $urandom;
    endcase
  endfunction

  initial begin
    board = new();
    rst = 1'b1;
    calm = 1'b1;
    stall_left = 0;
    cfg_wr_en = 1'b0;
    cfg_index = REG_HEIGHT;
    cfg_data = 32'd0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = 32'd0;
    m_axis_tready = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset orbit: zero step, one-second step, extremes of dt
    send_step(32'd0);
    send_step(32'h0001_0000);
    send_step(32'hFFFF_FFFF);
    send_step(32'h8000_0000);
    send_step(32'd1);
    // polar orbit starting over the pole: latitude at its limit
    set_orbit(32'd400000, 32'h4000_0000, 32'h1234_5678, 32'h4000_0000);
    send_step(32'd0);
    send_step(32'd1);
    set_orbit(32'd400000, 32'h4000_0000, 32'd0, 32'hC000_0000);
    send_step(32'd0);
    // lowest and highest heights, retrograde inclination
    set_orbit(32'd0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_step(32'd0);
    send_step(32'hFFFF_FFFF);
    set_orbit(32'hFFFF_FFFF, 32'd0, 32'h8000_0000, 32'h8000_0000);
    send_step(32'h0100_0000);
    send_step(32'h5555_5555);
    set_orbit(32'd10000000, 32'h2000_0000, 32'd0, 32'd0);
    send_step(32'hAAAA_AAAA);
    send_step(32'h0000_FFFF);

    calm = 1'b0;
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 0) set_orbit(32'd400000, 32'd615611979, 32'd0, 32'd0);
      else if (ph == 7) set_orbit(32'd0, 32'h4000_0000, $urandom, $urandom);
      else begin
        drain();
        repeat ($urandom_range(2, 6)) write_reg(2'($urandom_range(0, 3)), $urandom);
      end
      calm = (ph == 3);
      for (int k = 0; k < 200; k++) send_step(rand_dt());
    end

    drain();
    repeat (300) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("orbit_subpoint_propagator_core test passed");
    end else begin
      $display("orbit_subpoint_propagator_core test failed");
    end
    $finish;
  end

endmodule
